>>> rtl/separable_block_fitness_top_defines.svh
// assertion macros for the separable block fitness scorer
`ifndef SEPARABLE_BLOCK_FITNESS_TOP_DEFINES_SVH
`define SEPARABLE_BLOCK_FITNESS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbf assertion failed");
`define SBF_ASSERT_NEVER(label, clk, rst, expr) \
   `SBF_ASSERT(label, clk, rst, !(expr))
`else
`define SBF_ASSERT(label, clk, rst, prop)
`define SBF_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

>>> rtl/sbf_pkg.sv
// shared types and constants for the separable block fitness scorer
package sbf_pkg;

   localparam int unsigned BLOCK_W     = 6;
   localparam int unsigned ACC_W       = 29;
   localparam int unsigned UNIT_W      = 3;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned CSR_IDX_BIT = 2;
   localparam longint unsigned MICRO_SCALE = 64'd1000000;

   typedef enum logic [MODE_W-1:0] {
      MODE_ONEMAX      = 3'd0,
      MODE_QUADRATIC   = 3'd1,
      MODE_DECEPTIVE3  = 3'd2,
      MODE_TRAP5       = 3'd3,
      MODE_BIPOLAR6    = 3'd4,
      MODE_MMDP6       = 3'd5
   } mode_type;

   typedef enum logic [0:0] {
      REG_FITNESS_MODE = 1'b0
   } csr_reg_type;

   // rounds a value given in millionths to fixed point with fb fraction bits
   function automatic logic [63:0] fix_micro(input logic [31:0] micro,
                                             input logic [4:0]  fb);
      logic [63:0] scaled;
      scaled = (64'(micro) << fb) + (MICRO_SCALE / 64'd2);
      return scaled / MICRO_SCALE;
   endfunction

endpackage

>>> rtl/sbf_channels.sv
// handshake channels carrying block words and fitness words
interface sbf_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbf_pkg::BLOCK_W-1:0]   block_bits;
   logic                          last_block;

   modport source (output valid, output block_bits, output last_block, input ready);
   modport sink   (input valid, input block_bits, input last_block, output ready);
endinterface

interface sbf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbf_pkg::ACC_W-1:0]     fitness_sum;

   modport source (output valid, output fitness_sum, input ready);
   modport sink   (input valid, input fitness_sum, output ready);
endinterface

>>> rtl/sbf_score.sv
// per-block score: masked unitation and table pick for the selected mode
module sbf_score #(
   parameter int unsigned FRACTION_BITS = 16,
   localparam int unsigned SCORE_W = FRACTION_BITS + 3
) (
   input  sbf_pkg::mode_type               mode,
   input  logic [sbf_pkg::BLOCK_W-1:0]     block_bits,
   output logic [SCORE_W-1:0]              score
);

   localparam logic [4:0] FB = 5'(FRACTION_BITS);
   localparam logic [SCORE_W-1:0] S_ONE   = SCORE_W'(1) << FRACTION_BITS;
   localparam logic [SCORE_W-1:0] S_FIVE  = SCORE_W'(5) << FRACTION_BITS;
   localparam logic [SCORE_W-1:0] S_0P9   = SCORE_W'(sbf_pkg::fix_micro(32'd900000, FB));
   localparam logic [SCORE_W-1:0] S_0P8   = SCORE_W'(sbf_pkg::fix_micro(32'd800000, FB));
   localparam logic [SCORE_W-1:0] S_MM24  = SCORE_W'(sbf_pkg::fix_micro(32'd360384, FB));
   localparam logic [SCORE_W-1:0] S_MM3   = SCORE_W'(sbf_pkg::fix_micro(32'd640576, FB));

   logic [sbf_pkg::BLOCK_W-1:0] mask;
   logic [sbf_pkg::BLOCK_W-1:0] genes;
   logic [sbf_pkg::UNIT_W-1:0]  ones;
   logic [sbf_pkg::UNIT_W-1:0]  spread;

   function automatic logic [SCORE_W-1:0] deceptive(input logic [1:0] level);
      logic [SCORE_W-1:0] val;
      unique case (level)
         2'd0:    val = S_0P9;
         2'd1:    val = S_0P8;
         2'd3:    val = S_ONE;
         default: val = '0;
      endcase
      return val;
   endfunction

   always_comb begin
      unique case (mode)
         sbf_pkg::MODE_ONEMAX:     mask = 6'b000001;
         sbf_pkg::MODE_QUADRATIC:  mask = 6'b000011;
         sbf_pkg::MODE_DECEPTIVE3: mask = 6'b000111;
         sbf_pkg::MODE_TRAP5:      mask = 6'b011111;
         sbf_pkg::MODE_BIPOLAR6,
         sbf_pkg::MODE_MMDP6:      mask = 6'b111111;
         default:                  mask = '0;
      endcase
      genes = block_bits & mask;
      ones  = '0;
      for (int i = 0; i < sbf_pkg::BLOCK_W; i++) begin
         ones = ones + sbf_pkg::UNIT_W'(genes[i]);
      end
      spread = (ones >= 3'd3) ? (ones - 3'd3) : (3'd3 - ones);
   end

   always_comb begin
      unique case (mode)
         sbf_pkg::MODE_ONEMAX: begin
            score = genes[0] ? S_ONE : '0;
         end
         sbf_pkg::MODE_QUADRATIC: begin
            unique case (genes[1:0])
               2'b00:   score = S_0P9;
               2'b11:   score = S_ONE;
               default: score = '0;
            endcase
         end
         sbf_pkg::MODE_DECEPTIVE3: begin
            score = deceptive(ones[1:0]);
         end
         sbf_pkg::MODE_TRAP5: begin
            score = (ones == 3'd5) ? S_FIVE
                  : (SCORE_W'(3'd4 - ones) << FRACTION_BITS);
         end
         sbf_pkg::MODE_BIPOLAR6: begin
            score = deceptive(spread[1:0]);
         end
         sbf_pkg::MODE_MMDP6: begin
            unique case (ones)
               3'd0, 3'd6: score = S_ONE;
               3'd2, 3'd4: score = S_MM24;
               3'd3:       score = S_MM3;
               default:    score = '0;
            endcase
         end
         default: begin
            score = '0;
         end
      endcase
   end

endmodule

>>> rtl/separable_block_fitness_top.sv
// separable block fitness scorer: top level with csr port and accumulator
// Takes one chromosome block word per cycle unless stalled (see below). A word
// is registered on acceptance; in the next cycle its block score (popcount and
// table pick for the configured mode) is added into the saturating accumulator.
// A word marked last moves the total into the result register and clears the
// accumulator, and the fitness word is presented from that register. A result
// waiting at the output only holds the input side back when a further last
// block reaches the accumulator stage. The mode register sits at byte address
// 0; users write it only while no word is in flight; the block does not check.
`include "separable_block_fitness_top_defines.svh"

module separable_block_fitness_top #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   sbf_req_if.sink                           req_chan,
   sbf_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sbf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sbf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sbf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int unsigned SCORE_W = FRACTION_BITS + 3;
   localparam int unsigned SUM_W   = sbf_pkg::ACC_W + 1;

   sbf_pkg::mode_type              mode_ff, mode_in;
   logic                           s1_valid_ff, s1_valid_in;
   logic [sbf_pkg::BLOCK_W-1:0]    s1_bits_ff, s1_bits_in;
   logic                           s1_last_ff, s1_last_in;
   logic [sbf_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic                           out_valid_ff, out_valid_in;
   logic [sbf_pkg::ACC_W-1:0]      out_sum_ff, out_sum_in;

   logic [SCORE_W-1:0]             score;
   logic [SUM_W-1:0]               sum_wide;
   logic [sbf_pkg::ACC_W-1:0]      sum_sat;
   logic                           stall;
   logic                           advance;
   logic                           req_take;
   logic                           csr_wr;
   sbf_pkg::csr_reg_type           csr_idx;

   sbf_score #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_score (
      .mode       (mode_ff),
      .block_bits (s1_bits_ff),
      .score      (score)
   );

   // register interface
   assign pready  = 1'b1;
   assign csr_idx = sbf_pkg::csr_reg_type'(paddr[sbf_pkg::CSR_IDX_BIT]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_idx)
         sbf_pkg::REG_FITNESS_MODE: prdata = sbf_pkg::CSR_DATA_W'(mode_ff);
         default:                   prdata = '0;
      endcase
   end

   // datapath
   assign stall    = s1_valid_ff && s1_last_ff && out_valid_ff && !rsp_chan.ready;
   assign advance  = s1_valid_ff && !stall;
   assign req_chan.ready = !s1_valid_ff || !stall;
   assign req_take = req_chan.valid && req_chan.ready;

   assign sum_wide = {1'b0, acc_ff} + SUM_W'(score);
   assign sum_sat  = sum_wide[SUM_W-1] ? '1 : sum_wide[sbf_pkg::ACC_W-1:0];

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_idx == sbf_pkg::REG_FITNESS_MODE) begin
         mode_in = sbf_pkg::mode_type'(pwdata[sbf_pkg::MODE_W-1:0]);
      end

      s1_valid_in = s1_valid_ff;
      s1_bits_in  = s1_bits_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_bits_in  = req_chan.block_bits;
         s1_last_in  = req_chan.last_block;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      out_sum_in   = out_sum_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         if (s1_last_ff) begin
            acc_in       = '0;
            out_valid_in = 1'b1;
            out_sum_in   = sum_sat;
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sbf_pkg::MODE_ONEMAX;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bits_ff <= s1_bits_in;
      s1_last_ff <= s1_last_in;
      out_sum_ff <= out_sum_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.fitness_sum = out_sum_ff;

   `SBF_ASSERT(a_last_clears_acc, clock, reset, advance && s1_last_ff |=> acc_ff == '0)
   `SBF_ASSERT(a_rsp_from_last, clock, reset, $rose(out_valid_ff) |-> $past(advance && s1_last_ff))
   `SBF_ASSERT_NEVER(a_stall_blocks_req, clock, reset, stall && req_chan.ready)
   `SBF_ASSERT(a_plain_word_no_rsp, clock, reset, advance && !s1_last_ff && !out_valid_ff |=> !out_valid_ff)

endmodule
